// File: src/lz4d_pkg.sv
// ---------------------------------------------------------------------------
// lz4d_pkg
// shared widths, phase and status codes and the state and step bundles of
// the lz4 block decoder
// ---------------------------------------------------------------------------
`default_nettype none

package lz4d_pkg;

   localparam int WIN_AW     = 16;        // history address bits (64 KiB)
   localparam int CNT_W      = 25;        // output byte counter
   localparam int LEN_W      = 24;        // input length and consumed count
   localparam int MAX_LENGTH = 16777216;  // longest extended length

   // parser phases
   localparam logic [2:0] PH_TOKEN    = 3'd0;
   localparam logic [2:0] PH_LITEXT   = 3'd1;
   localparam logic [2:0] PH_LIT      = 3'd2;
   localparam logic [2:0] PH_OFF_LO   = 3'd3;
   localparam logic [2:0] PH_OFF_HI   = 3'd4;
   localparam logic [2:0] PH_MATCHEXT = 3'd5;
   localparam logic [2:0] PH_COPY     = 3'd6;

   // result status codes
   localparam logic [2:0] ST_WORK     = 3'd0;
   localparam logic [2:0] ST_REFUSED  = 3'd1;
   localparam logic [2:0] ST_DONE     = 3'd2;
   localparam logic [2:0] ST_INPUT    = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;
   localparam logic [2:0] ST_OFFSET   = 3'd5;

   // operation codes of an input transaction
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // register indexes
   localparam logic CSR_INPUT_LENGTH    = 1'b0;
   localparam logic CSR_OUTPUT_CAPACITY = 1'b1;

   typedef struct packed {
      logic [2:0]        phase;
      logic [CNT_W-1:0]  run;
      logic [3:0]        nibble;
      logic [15:0]       offset;
      logic [LEN_W-1:0]  consumed;
      logic [CNT_W-1:0]  produced;
   } lz4d_state_type;

   typedef struct packed {
      logic              out_valid;
      logic              copy;      // byte comes from the history read
      logic [7:0]        lit_byte;  // literal byte, zero when not a literal
      logic [2:0]        status;
      logic [CNT_W-1:0]  count;
   } lz4d_result_type;

endpackage

`default_nettype wire

// File: src/lz4d_ram.sv
// ---------------------------------------------------------------------------
// lz4d_ram
// generic single-clock ram, one write and one registered read port,
// read-first on a same-address collision
// ---------------------------------------------------------------------------
`default_nettype none

module lz4d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: src/lz4d_parse.sv
// ---------------------------------------------------------------------------
// lz4d_parse
// next-state and result logic for one input transaction: token, length
// extension, literal, offset and copy handling with the block checks
// ---------------------------------------------------------------------------
`default_nettype none

module lz4d_parse (
   input  wire lz4d_pkg::lz4d_state_type      cur,
   input  wire logic [lz4d_pkg::LEN_W-1:0]    input_length,
   input  wire logic [lz4d_pkg::CNT_W-1:0]    output_capacity,
   input  wire logic                          op,
   input  wire logic [7:0]                    data,
   output lz4d_pkg::lz4d_state_type           nxt,
   output lz4d_pkg::lz4d_result_type          res
);

   import lz4d_pkg::*;

   logic [LEN_W-1:0] c1;
   logic             last;
   logic [CNT_W:0]   v26;
   logic             v_big;
   logic [CNT_W-1:0] v25;
   logic [CNT_W-1:0] cand;
   logic             in_short;
   logic             over;
   logic [CNT_W-1:0] run_dec;
   logic [15:0]      off_n;
   logic             lk_go;
   logic             sc_go;

   assign c1      = cur.consumed + LEN_W'(1);
   assign last    = (c1 == input_length);
   assign v26     = {1'b0, cur.run} + {{(CNT_W-7){1'b0}}, data};
   assign v_big   = v26 > (CNT_W+1)'(MAX_LENGTH);
   assign v25     = v26[CNT_W-1:0];
   assign run_dec = (cur.run == '0) ? '0 : cur.run - CNT_W'(1);
   assign off_n   = {data, cur.offset[7:0]};

   // run length that the literal or copy checks look at
   always_comb begin
      case (cur.phase)
         PH_TOKEN:    cand = {{(CNT_W-4){1'b0}}, data[7:4]};
         PH_LITEXT:   cand = v25;
         PH_OFF_HI:   cand = {{(CNT_W-4){1'b0}}, cur.nibble} + CNT_W'(4);
         PH_MATCHEXT: cand = v25 + CNT_W'(4);
         default:     cand = '0;
      endcase
   end

   assign in_short = ({2'b00, c1} + {1'b0, cand}) > {2'b00, input_length};
   assign over     = (cand != '0) &&
                     (({1'b0, cur.produced} + {1'b0, cand}) > {1'b0, output_capacity});

   always_comb begin
      nxt          = cur;
      res          = '0;
      res.status   = ST_WORK;
      lk_go        = 1'b0;
      sc_go        = 1'b0;

      if (op == OP_TICK) begin
         if (cur.phase == PH_COPY) begin
            res.out_valid = 1'b1;
            res.copy      = 1'b1;
            nxt.produced  = cur.produced + CNT_W'(1);
            nxt.run       = run_dec;
            if (run_dec == '0) begin
               nxt.phase = PH_TOKEN;
               if (cur.consumed >= input_length) begin
                  res.status = ST_INPUT;
               end
            end
         end
      end else if (cur.phase == PH_COPY) begin
         res.status = ST_REFUSED;
      end else if (cur.consumed >= input_length) begin
         res.status = ST_INPUT;
      end else begin
         nxt.consumed = c1;
         case (cur.phase)
            PH_TOKEN: begin
               nxt.nibble = data[3:0];
               nxt.run    = cand;
               if (data[7:4] == 4'hF) begin
                  nxt.phase = PH_LITEXT;
                  if (last) begin
                     res.status = ST_INPUT;
                  end
               end else begin
                  lk_go = 1'b1;
               end
            end
            PH_LITEXT: begin
               if (v_big) begin
                  res.status = ST_INPUT;
               end else begin
                  nxt.run = v25;
                  if (data == 8'hFF) begin
                     if (last) begin
                        res.status = ST_INPUT;
                     end
                  end else begin
                     lk_go = 1'b1;
                  end
               end
            end
            PH_LIT: begin
               res.out_valid = 1'b1;
               res.lit_byte  = data;
               nxt.produced  = cur.produced + CNT_W'(1);
               nxt.run       = run_dec;
               if (run_dec == '0) begin
                  if (last) begin
                     res.status = ST_DONE;
                  end else begin
                     nxt.phase = PH_OFF_LO;
                  end
               end else if (last) begin
                  res.status = ST_INPUT;
               end
            end
            PH_OFF_LO: begin
               nxt.offset = {8'h00, data};
               nxt.phase  = PH_OFF_HI;
               if (last) begin
                  res.status = ST_INPUT;
               end
            end
            PH_OFF_HI: begin
               nxt.offset = off_n;
               if (off_n == '0 || cur.produced < {{(CNT_W-16){1'b0}}, off_n}) begin
                  res.status = ST_OFFSET;
               end else if (cur.nibble == 4'hF) begin
                  nxt.run   = CNT_W'(15);
                  nxt.phase = PH_MATCHEXT;
                  if (last) begin
                     res.status = ST_INPUT;
                  end
               end else begin
                  nxt.run = cand;
                  sc_go   = 1'b1;
               end
            end
            PH_MATCHEXT: begin
               if (v_big) begin
                  res.status = ST_INPUT;
               end else if (data == 8'hFF) begin
                  nxt.run = v25;
                  if (last) begin
                     res.status = ST_INPUT;
                  end
               end else begin
                  nxt.run = cand;
                  sc_go   = 1'b1;
               end
            end
            default: begin
               nxt.phase = PH_TOKEN;
            end
         endcase
      end

      // literal count is final
      if (lk_go) begin
         if (in_short) begin
            res.status = ST_INPUT;
         end else if (over) begin
            res.status = ST_OVERFLOW;
         end else if (cand == '0) begin
            if (last) begin
               res.status = ST_DONE;
            end else begin
               nxt.phase = PH_OFF_LO;
            end
         end else begin
            nxt.phase = PH_LIT;
         end
      end

      // match length is final
      if (sc_go) begin
         if (over) begin
            res.status = ST_OVERFLOW;
         end else begin
            nxt.phase = PH_COPY;
         end
      end

      res.count = nxt.produced;

      // done or error starts a new block
      if (res.status >= ST_DONE) begin
         nxt = '0;
         nxt.phase = PH_TOKEN;
      end
   end

endmodule

`default_nettype wire

// File: src/lz4_block_decoder.sv
// ---------------------------------------------------------------------------
// lz4_block_decoder
// lz4 block decompressor, one compressed byte or one copy tick per cycle while the rsp channel is not stalled
//
// req channel: tuser is the op (0 compressed byte, 1 copy tick), tdata the
//   byte. every accepted transaction gives exactly one rsp transaction.
// rsp channel: out_valid, out_byte, status and out_count packed in tdata.
// csr port: input_length (index 0) and output_capacity (index 1), written
//   while the decoder is idle between blocks.
// the response is registered on acceptance.
// throughput: one transaction per cycle, bytes and copy ticks alike; the
//   history is a 64 KiB ram with one write and one read port, read once per
//   transaction and written once per output byte, with a bypass for a copy
//   that reads the byte being written in the same cycle (offset one).
// a stalled rsp channel holds the output register; req_tready falls only
//   while that register is full and not being taken.
// synchronous reset clears the parser, counters and control registers; the
//   payload registers and the history are not cleared, and need no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module lz4_block_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   // compressed input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data
   input  wire logic        req_tuser,   // [0] op
   // decompressed output
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [0] out_valid, [8:1] out_byte,
                                         // [11:9] status, [36:12] out_count,
                                         // [39:37] zero
   // configuration
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [24:0] csr_wdata
);

   import lz4d_pkg::*;

   // block configuration
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  cap_ff, cap_in;

   // parser state
   lz4d_state_type    st_ff, st_in, st_nxt;
   lz4d_result_type   res;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   lz4d_result_type   out_ff, out_in;

   // history write, in the cycle after acceptance once the byte is known
   logic              we_ff, we_in;
   logic [WIN_AW-1:0] waddr_ff, waddr_in;
   // bypass for a read of the entry being written in the same cycle
   logic              fwd_ff, fwd_in;
   logic [7:0]        fwd_byte_ff, fwd_byte_in;

   logic              accept;
   logic [WIN_AW-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic [7:0]        cur_byte;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   lz4d_parse u_parse (
      .cur             (st_ff),
      .input_length    (len_ff),
      .output_capacity (cap_ff),
      .op              (req_tuser),
      .data            (req_tdata),
      .nxt             (st_nxt),
      .res             (res)
   );

   // match source: distance back from the current write position
   assign rd_addr = st_ff.produced[WIN_AW-1:0] - st_ff.offset;

   // byte held by the output register
   assign cur_byte = out_ff.copy ? (fwd_ff ? fwd_byte_ff : rd_data) : out_ff.lit_byte;

   lz4d_ram #(
      .WIDTH (8),
      .DEPTH (2 ** WIN_AW)
   ) u_history (
      .clock   (clock),
      .wr_en   (we_ff),
      .wr_addr (waddr_ff),
      .wr_data (cur_byte),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      len_in       = len_ff;
      cap_in       = cap_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      we_in        = 1'b0;
      waddr_in     = waddr_ff;
      fwd_in       = fwd_ff;
      fwd_byte_in  = fwd_byte_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_INPUT_LENGTH:    len_in = csr_wdata[LEN_W-1:0];
            CSR_OUTPUT_CAPACITY: cap_in = csr_wdata;
            default:             len_in = len_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         st_in        = st_nxt;
         rsp_valid_in = 1'b1;
         out_in       = res;
         we_in        = res.out_valid;
         waddr_in     = st_ff.produced[WIN_AW-1:0];
         // the ram returns old data when the entry is written this cycle
         fwd_in       = we_ff && (rd_addr == waddr_ff);
         fwd_byte_in  = cur_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         cap_ff       <= '0;
         st_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         we_ff        <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         len_ff       <= len_in;
         cap_ff       <= cap_in;
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         we_ff        <= we_in;
         fwd_ff       <= fwd_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      out_ff      <= out_in;
      waddr_ff    <= waddr_in;
      fwd_byte_ff <= fwd_byte_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.count, out_ff.status, cur_byte, out_ff.out_valid};

endmodule

`default_nettype wire
